FILE: rtl/thrt_pkg.sv
package thrt_pkg;

    localparam int LOG_BITS  = 30;
    localparam int DIV_STEPS = 70;

    localparam logic [27:0] LN2_Q28    = 28'd186065280;
    localparam logic [63:0] SIGN64     = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAXPOS64   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_LIMIT  = 64'd86683131;
    localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
    localparam logic [23:0] TEMP_OFF   = 24'd279706;
    localparam logic [23:0] TEMP_MAX   = 24'h7F_FFFF;

    localparam logic [1:0] REG_CONST  = 2'd0;
    localparam logic [1:0] REG_LINEAR = 2'd1;
    localparam logic [1:0] REG_SQUARE = 2'd2;
    localparam logic [1:0] REG_CUBE   = 2'd3;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ZERO   = 2'd1,
        ST_NONPOS = 2'd2,
        ST_SAT    = 2'd3
    } t_status;

    // ln(R) with its sideband flags
    typedef struct packed {
        logic        valid;
        logic        zero;
        logic        lneg;
        logic [34:0] lmag;
    } t_lnv;

    typedef struct packed {
        t_lnv        ln;
        logic [63:0] acc;
    } t_hv;

    typedef struct packed {
        logic        valid;
        logic        zero;
        logic        np;
        logic        qhi;
        logic [63:0] qlo;
    } t_qv;

    typedef struct packed {
        logic        valid;
        t_status     st;
        logic [58:0] prod;
    } t_f1;

endpackage

FILE: rtl/thrt_if.sv
interface thrt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] resistance;

    modport source (output valid, output resistance, input ready);
    modport sink (input valid, input resistance, output ready);
endinterface

interface thrt_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] temperature;
    logic [1:0]  status;

    modport source (output valid, output temperature, output status, input ready);
    modport sink (input valid, input temperature, input status, output ready);
endinterface

FILE: rtl/thermistor_resistance_to_temp.sv
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    resistance[31:0]  Q24.8 ohms
// o_out     out  valid/ready    temperature[23:0] C/1024, status[1:0]
// apb       in   psel/penable   coefficients, 64-bit, at byte address 8*i
//
// One word per clock while i_in.ready is high; ready drops while a skid word is held.
// The pipeline holds 30 log squaring stages, 3x5 Horner stages and
// 70 restoring divide stages, one bit or one partial step each.
// Reset clears the valid bits and the coefficients (synchronous, i_rst_n low).
// On an output stall the pipeline runs until the two-word output buffer is
// full, then freezes as a whole; nothing is dropped or repeated.
module thermistor_resistance_to_temp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    thrt_in_if.sink     i_in,
    thrt_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0] r_c0;
    logic [63:0] r_c1;
    logic [63:0] r_c2;
    logic [63:0] r_c3;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
                thrt_pkg::REG_CONST:  r_c0 <= pwdata;
                thrt_pkg::REG_LINEAR: r_c1 <= pwdata;
                thrt_pkg::REG_SQUARE: r_c2 <= pwdata;
                thrt_pkg::REG_CUBE:   r_c3 <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            thrt_pkg::REG_CONST:  prdata = r_c0;
            thrt_pkg::REG_LINEAR: prdata = r_c1;
            thrt_pkg::REG_SQUARE: prdata = r_c2;
            thrt_pkg::REG_CUBE:   prdata = r_c3;
            default:              prdata = '0;
        endcase
    end

    logic r_skid_v;
    logic w_en;

    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;

    thrt_pkg::t_lnv w_lnv;
    thrt_pkg::t_hv  w_h0;
    thrt_pkg::t_hv  w_h1;
    thrt_pkg::t_hv  w_h2;
    thrt_pkg::t_hv  w_h3;
    thrt_pkg::t_qv  w_qv;

    thrt_log u_log (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_in.valid),
        .i_resistance (i_in.resistance),
        .o_lnv        (w_lnv)
    );

    assign w_h0.ln  = w_lnv;
    assign w_h0.acc = r_c3;

    thrt_hstep u_h2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_hv (w_h0), .i_coeff (r_c2), .o_hv (w_h1)
    );

    thrt_hstep u_h1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_hv (w_h1), .i_coeff (r_c1), .o_hv (w_h2)
    );

    thrt_hstep u_h0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en),
        .i_hv (w_h2), .i_coeff (r_c0), .o_hv (w_h3)
    );

    thrt_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_hv    (w_h3),
        .o_qv    (w_qv)
    );

    // kelvin*10240 to C/1024: floor((q + 9) / 10) - 279706
    thrt_pkg::t_f1    r_f1;
    thrt_pkg::t_status w_st;
    logic [26:0]      w_n;

    always_comb begin
        w_n = w_qv.qlo[26:0] + 27'd9;
        if (w_qv.zero) begin
            w_st = thrt_pkg::ST_ZERO;
        end else if (w_qv.np) begin
            w_st = thrt_pkg::ST_NONPOS;
        end else if (w_qv.qhi || (w_qv.qlo >= thrt_pkg::SAT_LIMIT)) begin
            w_st = thrt_pkg::ST_SAT;
        end else begin
            w_st = thrt_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1.valid <= 1'b0;
        end else if (w_en) begin
            r_f1.valid <= w_qv.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1.st   <= w_st;
            r_f1.prod <= 59'(w_n) * 59'(thrt_pkg::RECIP10);
        end
    end

    logic [23:0] w_temp;

    always_comb begin
        case (r_f1.st)
            thrt_pkg::ST_OK:  w_temp = r_f1.prod[58:35] - thrt_pkg::TEMP_OFF;
            thrt_pkg::ST_SAT: w_temp = thrt_pkg::TEMP_MAX;
            default:          w_temp = '0;
        endcase
    end

    logic        r_out_v;
    logic [23:0] r_out_t;
    logic [1:0]  r_out_s;
    logic [23:0] r_skid_t;
    logic [1:0]  r_skid_s;
    logic        w_take;

    assign w_take = r_out_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // pipeline frozen: drain the skid word
            if (w_take) begin
                r_out_t  <= r_skid_t;
                r_out_s  <= r_skid_s;
                r_skid_v <= 1'b0;
            end
        end else if (r_f1.valid) begin
            if (!r_out_v || w_take) begin
                r_out_t <= w_temp;
                r_out_s <= r_f1.st;
                r_out_v <= 1'b1;
            end else begin
                r_skid_t <= w_temp;
                r_skid_s <= r_f1.st;
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.temperature = r_out_t;
    assign o_out.status      = r_out_s;

    a_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held with empty output register");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_f1.valid))
        else $error("final stage moved while frozen");

    a_zero_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && ((r_out_s == thrt_pkg::ST_ZERO) || (r_out_s == thrt_pkg::ST_NONPOS)))
        |-> (r_out_t == 24'd0))
        else $error("error status with nonzero temperature");

    a_sat_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out_s == thrt_pkg::ST_SAT)) |-> (r_out_t == thrt_pkg::TEMP_MAX))
        else $error("saturated status without full-scale temperature");

endmodule

FILE: rtl/thrt_log.sv
module thrt_log (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [31:0]        i_resistance,
    output thrt_pkg::t_lnv     o_lnv
);

    localparam int NB = thrt_pkg::LOG_BITS;

    logic [NB:0]   r_v;
    logic [NB:0]   r_zero;
    logic [4:0]    r_msb  [0:NB];
    logic [31:0]   r_z    [0:NB];
    logic [NB-1:0] r_frac [0:NB];

    logic [4:0]  w_msb;
    logic [31:0] w_z;

    always_comb begin
        w_msb = '0;
        for (int b = 0; b < 32; b++) begin
            if (i_resistance[b]) begin
                w_msb = 5'(b);
            end
        end
        w_z = i_resistance << (5'd31 - w_msb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_resistance == 32'd0);
            r_msb[0]  <= w_msb;
            r_z[0]    <= w_z;
            r_frac[0] <= '0;
        end
    end

    // one fraction bit per stage by squaring
    for (genvar k = 0; k < NB; k++) begin : g_sq
        localparam int BI = NB - 1 - k;
        logic [63:0] w_sq;
        logic [32:0] w_s;

        assign w_sq = 64'(r_z[k]) * 64'(r_z[k]);
        assign w_s  = w_sq[63:31];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[k+1] <= r_zero[k];
                r_msb[k+1]  <= r_msb[k];
                if (w_s[32]) begin
                    r_z[k+1]    <= w_s[32:1];
                    r_frac[k+1] <= r_frac[k] | (NB'(1) << BI);
                end else begin
                    r_z[k+1]    <= w_s[31:0];
                    r_frac[k+1] <= r_frac[k];
                end
            end
        end
    end

    logic [34:0] w_lg;
    logic        r_pv;
    logic        r_pzero;
    logic        r_pneg;
    logic [62:0] r_prod;
    logic [62:0] w_rnd;

    always_comb begin
        if (r_msb[NB] >= 5'd8) begin
            w_lg = {r_msb[NB] - 5'd8, 30'd0} + 35'(r_frac[NB]);
        end else begin
            w_lg = {5'd8 - r_msb[NB], 30'd0} - 35'(r_frac[NB]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= 1'b0;
            o_lnv.valid <= 1'b0;
        end else if (i_en) begin
            r_pv        <= r_v[NB];
            o_lnv.valid <= r_pv;
        end
    end

    assign w_rnd = r_prod + 63'(28'h800_0000);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pzero    <= r_zero[NB];
            r_pneg     <= (r_msb[NB] < 5'd8);
            r_prod     <= 63'(w_lg) * 63'(thrt_pkg::LN2_Q28);
            o_lnv.zero <= r_pzero;
            o_lnv.lmag <= w_rnd[62:28];
            o_lnv.lneg <= r_pneg && (w_rnd[62:28] != 35'd0);
        end
    end

endmodule

FILE: rtl/thrt_hstep.sv
module thrt_hstep (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  thrt_pkg::t_hv   i_hv,
    input  logic [63:0]     i_coeff,
    output thrt_pkg::t_hv   o_hv
);

    thrt_pkg::t_lnv r_ln [0:3];

    logic [63:0] r_amag;
    logic        r_neg1;
    logic [63:0] r_pp0;
    logic [34:0] r_pp1;
    logic [63:0] r_pp2;
    logic [34:0] r_pp3;
    logic        r_neg2;
    logic [98:0] r_prod;
    logic        r_neg3;
    logic [63:0] r_sc;

    logic        w_sat;
    logic [63:0] w_mag;
    logic [63:0] w_sc;
    logic [63:0] w_sum;
    logic [63:0] w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_ln[k].valid <= 1'b0;
            end
            o_hv.ln.valid <= 1'b0;
        end else if (i_en) begin
            r_ln[0] <= i_hv.ln;
            for (int k = 1; k < 4; k++) begin
                r_ln[k] <= r_ln[k-1];
            end
            o_hv.ln <= r_ln[3];
        end
    end

    always_comb begin
        w_sat = |r_prod[98:93];
        w_mag = {1'b0, r_prod[92:30]};
        if (w_sat) begin
            w_sc = r_neg3 ? thrt_pkg::SIGN64 : thrt_pkg::MAXPOS64;
        end else begin
            w_sc = r_neg3 ? (64'd0 - w_mag) : w_mag;
        end
        w_sum = r_sc + i_coeff;
        if ((r_sc[63] == i_coeff[63]) && (w_sum[63] != r_sc[63])) begin
            w_acc = r_sc[63] ? thrt_pkg::SIGN64 : thrt_pkg::MAXPOS64;
        end else begin
            w_acc = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_amag <= i_hv.acc[63] ? (64'd0 - i_hv.acc) : i_hv.acc;
            r_neg1 <= i_hv.acc[63] ^ i_hv.ln.lneg;
            // partial products, 32 x 32 at most
            r_pp0  <= 64'(r_amag[31:0])  * 64'(r_ln[0].lmag[31:0]);
            r_pp1  <= 35'(r_amag[31:0])  * 35'(r_ln[0].lmag[34:32]);
            r_pp2  <= 64'(r_amag[63:32]) * 64'(r_ln[0].lmag[31:0]);
            r_pp3  <= 35'(r_amag[63:32]) * 35'(r_ln[0].lmag[34:32]);
            r_neg2 <= r_neg1;
            r_prod <= 99'(r_pp0) + (99'(r_pp1) << 32) + (99'(r_pp2) << 32)
                      + (99'(r_pp3) << 64);
            r_neg3 <= r_neg2;
            r_sc   <= w_sc;
            o_hv.acc <= w_acc;
        end
    end

endmodule

FILE: rtl/thrt_recip.sv
module thrt_recip (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  thrt_pkg::t_hv   i_hv,
    output thrt_pkg::t_qv   o_qv
);

    localparam int NS = thrt_pkg::DIV_STEPS;

    thrt_pkg::t_qv r_q [0:NS];
    logic [63:0]   r_d [0:NS];
    logic [63:0]   r_r [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q[0].valid <= 1'b0;
        end else if (i_en) begin
            r_q[0].valid <= i_hv.ln.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0].zero <= i_hv.ln.zero;
            r_q[0].np   <= (i_hv.acc == 64'd0) || i_hv.acc[63];
            r_q[0].qhi  <= 1'b0;
            r_q[0].qlo  <= '0;
            r_d[0]      <= i_hv.acc;
            r_r[0]      <= '0;
        end
    end

    // restoring division of 5*2^67, one quotient bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_div
        localparam int  BI  = NS - 1 - k;
        localparam logic DB = (BI == 69) || (BI == 67);
        logic [63:0] w_t;
        logic        w_ge;

        assign w_t  = {r_r[k][62:0], DB};
        assign w_ge = (w_t >= r_d[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q[k+1].valid <= 1'b0;
            end else if (i_en) begin
                r_q[k+1].valid <= r_q[k].valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k+1].zero <= r_q[k].zero;
                r_q[k+1].np   <= r_q[k].np;
                r_d[k+1]      <= r_d[k];
                r_r[k+1]      <= w_ge ? (w_t - r_d[k]) : w_t;
                if (BI >= 64) begin
                    r_q[k+1].qhi <= r_q[k].qhi | w_ge;
                    r_q[k+1].qlo <= r_q[k].qlo;
                end else begin
                    r_q[k+1].qhi <= r_q[k].qhi;
                    r_q[k+1].qlo <= r_q[k].qlo | (64'(w_ge) << (BI % 64));
                end
            end
        end
    end

    assign o_qv = r_q[NS];

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import thrt_pkg::*;

    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         DRAIN_CYCLES   = 130;
    localparam logic [63:0] OFFSET_K10240 = 64'd2797056;

    // Expected temperatures, computed from the coefficients as the block holds them
    class temp_scoreboard;
        logic [63:0] coeff[4] = '{default: 64'd0};
        logic [23:0] temp_q[$];
        t_status     status_q[$];
        int          errors;
        int          checked;
        int          seen[4];

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        function logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
            logic [63:0] s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
                return a[63] ? SIGN64 : MAXPOS64;
            return s;
        endfunction

        // acc * ln / 2^30, truncated toward zero, clamped to 64 bits
        function logic [63:0] scale_by_ln(logic [63:0] acc, bit lneg, logic [63:0] lmag);
            logic [63:0]  amag;
            logic [127:0] prod;
            logic [63:0]  mag;
            bit           neg;
            amag = acc[63] ? -acc : acc;
            neg  = acc[63] != lneg;
            prod = {64'd0, amag} * {64'd0, lmag};
            if (prod[127:93] != 0)
                return neg ? SIGN64 : MAXPOS64;
            mag = prod[93:30];
            return neg ? -mag : mag;
        endfunction

        function void note_input(logic [31:0] res);
            logic [63:0]  z, frac, lgmag, lmag, acc, qlo;
            logic [127:0] q;
            bit           lneg;
            int           msb, e;
            longint       d, t;
            if (res == 0) begin
                temp_q.push_back(24'd0);
                status_q.push_back(ST_ZERO);
                return;
            end
            msb = 31;
            while (!res[msb])
                msb--;
            z = {32'd0, res} << (31 - msb);
            frac = 0;
            for (int i = 29; i >= 0; i--) begin
                z = (z * z) >> 31;
                if (z[32]) begin
                    frac[i] = 1'b1;
                    z = z >> 1;
                end
            end
            e = msb - 8;
            if (e >= 0) begin
                lneg  = 0;
                lgmag = (64'(e) << 30) + frac;
            end else begin
                lneg  = 1;
                lgmag = (64'(-e) << 30) - frac;
            end
            lmag = (lgmag * 64'(LN2_Q28) + (64'd1 << 27)) >> 28;
            if (lmag == 0)
                lneg = 0;
            acc = coeff[REG_CUBE];
            acc = add_clamped(scale_by_ln(acc, lneg, lmag), coeff[REG_SQUARE]);
            acc = add_clamped(scale_by_ln(acc, lneg, lmag), coeff[REG_LINEAR]);
            acc = add_clamped(scale_by_ln(acc, lneg, lmag), coeff[REG_CONST]);
            if (acc == 0 || acc[63]) begin
                temp_q.push_back(24'd0);
                status_q.push_back(ST_NONPOS);
                return;
            end
            q   = (128'd5 << 67) / {64'd0, acc};
            qlo = q[63:0];
            if (q[127:64] != 0 || qlo >= SAT_LIMIT) begin
                temp_q.push_back(TEMP_MAX);
                status_q.push_back(ST_SAT);
                return;
            end
            d = longint'(qlo) - longint'(OFFSET_K10240) + 5;
            t = (d >= 0) ? d / 10 : -((-d + 9) / 10);
            temp_q.push_back(t[23:0]);
            status_q.push_back(ST_OK);
        endfunction

        function void check_result(logic [23:0] temp, logic [1:0] st);
            logic [23:0] et;
            t_status     es;
            if (temp_q.size() == 0) begin
                report($sformatf("unexpected word temp=%0d status=%0d", $signed(temp), st));
                return;
            end
            et = temp_q.pop_front();
            es = status_q.pop_front();
            checked++;
            seen[es]++;
            if (st !== es)
                report($sformatf("status %0d, expected %s", st, es.name()));
            if (temp !== et)
                report($sformatf("temperature %0d, expected %0d", $signed(temp), $signed(et)));
        endfunction

        function int pending();
            return temp_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata, prdata;
    logic        pready;
    bit          steady;
    int          cycles;

    thrt_in_if  in_if();
    thrt_out_if out_if();
    temp_scoreboard sb;

    thermistor_resistance_to_temp dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            sb.note_input(in_if.resistance);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result(out_if.temperature, out_if.status);
    end

    // stall the output at random unless in a steady stretch
    always @(negedge i_clk)
        out_if.ready <= steady || ($urandom_range(99) >= 31);

    task automatic apb_write(logic [1:0] idx, logic [63:0] value);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        pwrite  <= 0;
        penable <= 0;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value)
            sb.report($sformatf("reg %0d reads %h, wrote %h", idx, prdata, value));
        @(negedge i_clk);
        psel    <= 0;
        penable <= 0;
        sb.coeff[idx] = value;
    endtask

    task automatic load_coeffs(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
                               logic [63:0] c3);
        apb_write(REG_CONST, c0);
        apb_write(REG_LINEAR, c1);
        apb_write(REG_SQUARE, c2);
        apb_write(REG_CUBE, c3);
    endtask

    // call at a falling edge; returns at a falling edge
    task automatic send_word(logic [31:0] res);
        while (!steady && $urandom_range(99) < 31) begin
            in_if.valid <= 0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1;
        in_if.resistance <= res;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_if.valid <= 0;
        while (sb.pending() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_resistance();
        int sel;
        sel = $urandom_range(99);
        if (sel < 3)  return 32'd0;
        if (sel < 45) return $urandom_range(256 * 100, 256 * 500000);
        if (sel < 60) return $urandom_range(1, 255);
        return $urandom();
    endfunction

    task automatic random_words(int count);
        for (int n = 0; n < count; n++) begin
            steady = (n >= count / 3 && n < count / 3 + 60);
            send_word(pick_resistance());
        end
        steady = 0;
    endtask

    logic [31:0] directed[] = '{32'd0, 32'd1, 32'd255, 32'd256, 32'd257, 32'd512,
        32'd2560000, 32'd25600, 32'd256000000, 32'h7FFF_FFFF, 32'h8000_0000,
        32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'd3};
    logic [63:0] sh_a, sh_b, sh_c, sh_d;

    initial begin
        sb = new();
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_if.valid = 0; in_if.resistance = 0; out_if.ready = 0;
        steady = 0; cycles = 0;
        sh_a = longint'(1.129148e-3 * 2.0 ** 56);
        sh_b = longint'(2.34125e-4 * 2.0 ** 56);
        sh_c = longint'(-2.0e-6 * 2.0 ** 56);
        sh_d = longint'(8.76741e-8 * 2.0 ** 56);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // coefficients still zero after reset: polynomial not positive
        foreach (directed[k]) send_word(directed[k]);
        drain();

        load_coeffs(sh_a, sh_b, 64'd0, sh_d);
        foreach (directed[k]) send_word(directed[k]);
        random_words(300);
        drain();

        load_coeffs(MAXPOS64, MAXPOS64, MAXPOS64, MAXPOS64);
        random_words(40);
        drain();
        load_coeffs(SIGN64, SIGN64, SIGN64, SIGN64);
        random_words(40);
        drain();
        // tiny positive constant: kelvin far above range
        load_coeffs(64'd1 << 20, 64'd0, 64'd0, 64'd0);
        random_words(30);
        drain();
        load_coeffs({$urandom(), $urandom()}, {$urandom(), $urandom()},
                    {$urandom(), $urandom()}, {$urandom(), $urandom()});
        random_words(80);
        drain();
        load_coeffs(sh_a, sh_b, sh_c, sh_d);
        random_words(300);
        drain();

        $display("Checked %0d temperatures: %0d ok, %0d zero, %0d not positive, %0d saturated",
                 sb.checked, sb.seen[ST_OK], sb.seen[ST_ZERO], sb.seen[ST_NONPOS],
                 sb.seen[ST_SAT]);
        $display("Seven coefficient sets including both extremes, random stalls on both sides");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/thrt_pkg.sv
rtl/thrt_if.sv
rtl/thrt_log.sv
rtl/thrt_hstep.sv
rtl/thrt_recip.sv
rtl/thermistor_resistance_to_temp.sv
dv/tb.sv
